[sv/ntp_header_extension_parser_defines.svh]
// ----------------------------------------------------------------------------
// NTP header parser assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef NTP_HEADER_EXTENSION_PARSER_DEFINES_SVH
`define NTP_HEADER_EXTENSION_PARSER_DEFINES_SVH

// same-cycle implication, gated by reset
`define NTPHEP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, gated by reset
`define NTPHEP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ntphep_pkg.sv]
// ----------------------------------------------------------------------------
// NTP header parser package
// Constants and result layout shared by the parser and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ntphep_pkg;

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 96;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int MAX_EXTENSIONS_DEFAULT = 8;

    localparam logic [15:0] HDR_LEN            = 16'd48;
    localparam logic [15:0] MIN_FIELD_LEN      = 16'd16;
    localparam logic [15:0] DEFAULT_MATCH_PORT = 16'd123;
    localparam logic [15:0] POS_MAX            = 16'hFFFF;

    localparam logic [2:0] VERSION_MIN = 3'd1;
    localparam logic [2:0] VERSION_MAX = 3'd4;

    // register index, taken from paddr[2]
    localparam logic REG_MATCH_PORT = 1'b0;

    typedef enum logic [1:0] {
        CLASS_NONE  = 2'd0,
        CLASS_OTHER = 2'd1,
        CLASS_PORT  = 2'd2
    } detect_class_t;

    typedef enum logic [1:0] {
        FLD_TYPE_HI = 2'd0,
        FLD_TYPE_LO = 2'd1,
        FLD_LEN_HI  = 2'd2,
        FLD_LEN_LO  = 2'd3
    } field_off_t;

    typedef struct packed {
        logic [5:0]  pad;
        logic        mac_present;
        logic [3:0]  ext_count;
        logic [31:0] reference_id;
        logic [7:0]  stratum_level;
        logic [1:0]  leap_indicator;
        logic [2:0]  mode_number;
        logic [2:0]  version_number;
        logic [1:0]  detect_class;
        logic [15:0] ext_length;
        logic [15:0] ext_type;
        logic [2:0]  ext_index;
    } result_t;

endpackage

`default_nettype wire

[sv/ntp_header_extension_parser.sv]
// Result path: the input register, then the result register.
// Throughput: one byte item per cycle; the result register stalls only on m_tready.
// Reset: synchronous, active low; clears valid flags, per-packet state and sets
// the match port to 123. A summary item also returns per-packet state to reset values.
// ----------------------------------------------------------------------------
// NTP header and extension parser
// Captures NTP header fields, walks extension fields, reports each well-formed field
// of a detected NTP packet (up to MAX_EXTENSIONS), and a per-packet summary on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ntp_header_extension_parser
    import ntphep_pkg::*;
#(
    parameter int MAX_EXTENSIONS = MAX_EXTENSIONS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // data_byte, packet_length, dest_port
    input  wire logic                  s_tuser,   // is_udp
    input  wire logic                  s_tlast,   // last_byte

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // ext_index, ext_type, ext_length, detect_class, version_number, mode_number,
    // leap_indicator, stratum_level, reference_id, ext_count, mac_present, zero pad
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tlast,   // result_kind

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam logic [3:0] MAX_EXT = 4'(MAX_EXTENSIONS);

    logic [15:0] match_port_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic [15:0] in_len_reg;
    logic [15:0] in_port_reg;
    logic        in_udp_reg;
    logic        in_last_reg;

    logic [15:0] pos_reg,     pos_next;
    logic [7:0]  fhb_reg,     fhb_next;
    logic [7:0]  stratum_reg, stratum_next;
    logic [31:0] refid_reg,   refid_next;
    logic [15:0] nfs_reg,     nfs_next;
    logic [15:0] ftype_reg,   ftype_next;
    logic [7:0]  lenhi_reg,   lenhi_next;
    logic [3:0]  cnt_reg,     cnt_next;
    logic        stop_reg,    stop_next;

    logic        out_valid_reg, out_valid_next;
    result_t     out_reg,       out_next;
    logic        out_last_reg;

    logic        advance;
    logic        cfg_write;

    logic [2:0]  version;
    logic [2:0]  mode;
    logic [1:0]  cls;
    logic [15:0] off;
    logic        in_field;
    logic [15:0] flen;
    logic        bad;
    logic        report;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = out_last_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_MATCH_PORT) ? {16'd0, match_port_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_port_reg <= DEFAULT_MATCH_PORT;
        end else if (cfg_write && paddr[2] == REG_MATCH_PORT) begin
            match_port_reg <= pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata[7:0];
            in_len_reg  <= s_tdata[23:8];
            in_port_reg <= s_tdata[39:24];
            in_udp_reg  <= s_tuser;
            in_last_reg <= s_tlast;
        end
    end

    always_comb begin
        pos_next     = pos_reg;
        fhb_next     = fhb_reg;
        stratum_next = stratum_reg;
        refid_next   = refid_reg;
        nfs_next     = nfs_reg;
        ftype_next   = ftype_reg;
        lenhi_next   = lenhi_reg;
        cnt_next     = cnt_reg;
        stop_next    = stop_reg;
        out_next     = '0;
        report       = 1'b0;
        bad          = 1'b0;
        flen         = {lenhi_reg, in_byte_reg};

        if (pos_reg == 16'd0) begin
            fhb_next = in_byte_reg;
        end else if (pos_reg == 16'd1) begin
            stratum_next = in_byte_reg;
        end else if (pos_reg >= 16'd12 && pos_reg <= 16'd15) begin
            refid_next = {refid_reg[23:0], in_byte_reg};
        end

        version = fhb_next[5:3];
        mode    = fhb_next[2:0];
        cls     = CLASS_NONE;
        if (in_udp_reg && in_len_reg >= HDR_LEN && version >= VERSION_MIN &&
            version <= VERSION_MAX && mode != 3'd0) begin
            cls = (in_port_reg == match_port_reg) ? CLASS_PORT : CLASS_OTHER;
        end

        off      = pos_reg - nfs_reg;
        in_field = !stop_reg && cnt_reg < MAX_EXT && pos_reg >= nfs_reg && off < 16'd4;

        if (in_field) begin
            case (field_off_t'(off[1:0]))
                FLD_TYPE_HI: ftype_next = {in_byte_reg, 8'd0};
                FLD_TYPE_LO: ftype_next = {ftype_reg[15:8], in_byte_reg};
                FLD_LEN_HI:  lenhi_next = in_byte_reg;
                FLD_LEN_LO: begin
                    bad = ({1'b0, nfs_reg} + 17'd4 > {1'b0, in_len_reg}) ||
                          (flen < MIN_FIELD_LEN) ||
                          ({1'b0, nfs_reg} + {1'b0, flen} > {1'b0, in_len_reg});
                    if (bad) begin
                        stop_next = 1'b1;
                    end else begin
                        report              = (cls != CLASS_NONE);
                        out_next.ext_index  = cnt_reg[2:0];
                        out_next.ext_type   = ftype_reg;
                        out_next.ext_length = flen;
                        nfs_next            = nfs_reg + flen;
                        cnt_next            = cnt_reg + 4'd1;
                    end
                end
                default: ;
            endcase
        end

        if (pos_reg != POS_MAX) begin
            pos_next = pos_reg + 16'd1;
        end

        out_valid_next = report || in_last_reg;

        if (in_last_reg) begin
            out_next              = '0;
            out_next.detect_class = cls;
            if (cls != CLASS_NONE) begin
                out_next.version_number = version;
                out_next.mode_number    = mode;
                out_next.leap_indicator = fhb_next[7:6];
                out_next.stratum_level  = stratum_next;
                out_next.reference_id   = refid_next;
                out_next.ext_count      = cnt_next;
                out_next.mac_present    = nfs_next < in_len_reg;
            end
            pos_next     = 16'd0;
            fhb_next     = 8'd0;
            stratum_next = 8'd0;
            refid_next   = 32'd0;
            nfs_next     = HDR_LEN;
            ftype_next   = 16'd0;
            lenhi_next   = 8'd0;
            cnt_next     = 4'd0;
            stop_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= 16'd0;
            fhb_reg     <= 8'd0;
            stratum_reg <= 8'd0;
            refid_reg   <= 32'd0;
            nfs_reg     <= HDR_LEN;
            ftype_reg   <= 16'd0;
            lenhi_reg   <= 8'd0;
            cnt_reg     <= 4'd0;
            stop_reg    <= 1'b0;
        end else if (advance) begin
            pos_reg     <= pos_next;
            fhb_reg     <= fhb_next;
            stratum_reg <= stratum_next;
            refid_reg   <= refid_next;
            nfs_reg     <= nfs_next;
            ftype_reg   <= ftype_next;
            lenhi_reg   <= lenhi_next;
            cnt_reg     <= cnt_next;
            stop_reg    <= stop_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= advance && out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && out_valid_next) begin
            out_reg      <= out_next;
            out_last_reg <= in_last_reg;
        end
    end

endmodule

`default_nettype wire

[sv/ntphep_checker.sv]
// ----------------------------------------------------------------------------
// NTP header parser port checker
// Watches the result channel for stalls and field consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ntp_header_extension_parser_defines.svh"

module ntphep_checker
    import ntphep_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tlast
);

    `NTPHEP_ASSERT_NEXT(a_hold_stall, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    `NTPHEP_ASSERT_NOW(a_class_legal, aclk, aresetn, m_tvalid,
        m_tdata[36:35] != 2'd3, "illegal detection class")

    `NTPHEP_ASSERT_NOW(a_not_ntp_zero, aclk, aresetn,
        m_tvalid && m_tlast && m_tdata[36:35] == CLASS_NONE,
        m_tdata[95:37] == '0 && m_tdata[34:0] == '0, "non-NTP summary carries data")

    `NTPHEP_ASSERT_NOW(a_report_form, aclk, aresetn, m_tvalid && !m_tlast,
        m_tdata[95:35] == '0 && m_tdata[34:19] >= 16'd16, "malformed field report")

endmodule

bind ntp_header_extension_parser ntphep_checker u_ntphep_checker (.*);

`default_nettype wire
